// File: hdl/acmac_pkg.sv
`timescale 1ns / 1ps
package acmac_pkg;

  localparam int unsigned BlkW = 128;
  localparam int unsigned NumRounds = 10;
  localparam logic [7:0] CmacRb = 8'h87;
  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [4:0] FullBytes = 5'd16;

  typedef enum logic [0:0] {
    CfgKeyHigh = 1'b0,
    CfgKeyLow  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StKeyExp,
    StSubkey,
    StLoad,
    StEnc,
    StOut
  } state_e;

  typedef struct packed {
    logic start;
    logic first;
  } core_ctl_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] rcon(input logic [3:0] r);
    logic [7:0] v;
    unique case (r)
      4'd1: v = 8'h01;
      4'd2: v = 8'h02;
      4'd3: v = 8'h04;
      4'd4: v = 8'h08;
      4'd5: v = 8'h10;
      4'd6: v = 8'h20;
      4'd7: v = 8'h40;
      4'd8: v = 8'h80;
      4'd9: v = 8'h1b;
      4'd10: v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic logic [BlkW-1:0] dbl(input logic [BlkW-1:0] x);
    return {x[BlkW-2:0], 1'b0} ^ {{(BlkW-8){1'b0}}, (x[BlkW-1] ? CmacRb : 8'h00)};
  endfunction

endpackage

// File: hdl/acmac_ram.sv
`timescale 1ns / 1ps
module acmac_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: hdl/acmac_round.sv
`timescale 1ns / 1ps
// One AES round: sub bytes, shift rows, optional mix columns, add round key.
module acmac_round (
  input  logic [127:0] state_i,
  input  logic [127:0] rkey_i,
  input  logic         last_i,
  output logic [127:0] state_o
);
  logic [7:0] s [16];
  logic [7:0] t [16];
  logic [7:0] m [16];
  logic [7:0] a0, a1, a2, a3, al;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = state_i[127-8*i -: 8];
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[r+4*c] = acmac_pkg::sbox(s[r + 4*((c+r) & 3)]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      m[4*c]   = last_i ? a0 : (a0 ^ al ^ acmac_pkg::xtime(a0 ^ a1));
      m[4*c+1] = last_i ? a1 : (a1 ^ al ^ acmac_pkg::xtime(a1 ^ a2));
      m[4*c+2] = last_i ? a2 : (a2 ^ al ^ acmac_pkg::xtime(a2 ^ a3));
      m[4*c+3] = last_i ? a3 : (a3 ^ al ^ acmac_pkg::xtime(a3 ^ a0));
    end
    for (int i = 0; i < 16; i++) begin
      state_o[127-8*i -: 8] = m[i] ^ rkey_i[127-8*i -: 8];
    end
  end
endmodule

// File: hdl/acmac_keyexp.sv
`timescale 1ns / 1ps
// One key schedule step: next round key from the previous one.
module acmac_keyexp (
  input  logic [127:0] key_i,
  input  logic [3:0]   rnd_i,
  output logic [127:0] key_o
);
  logic [31:0] w0, w1, w2, w3, t;

  always_comb begin
    w0 = key_i[127:96];
    w1 = key_i[95:64];
    w2 = key_i[63:32];
    w3 = key_i[31:0];
    t = {acmac_pkg::sbox(w3[23:16]) ^ acmac_pkg::rcon(rnd_i), acmac_pkg::sbox(w3[15:8]),
         acmac_pkg::sbox(w3[7:0]), acmac_pkg::sbox(w3[31:24])};
    key_o[127:96] = w0 ^ t;
    key_o[95:64]  = w1 ^ w0 ^ t;
    key_o[63:32]  = w2 ^ w1 ^ w0 ^ t;
    key_o[31:0]   = w3 ^ w2 ^ w1 ^ w0 ^ t;
  end
endmodule

// File: hdl/aes128_cmac_engine.sv
`timescale 1ns / 1ps
// Channel | direction | handshake              | payload
// blk     | in        | blk_valid_i/blk_ready_o | block_high_i, block_low_i, valid_bytes_i, final_block_i
// mac     | out       | mac_valid_o/mac_ready_i | mac_high_o, mac_low_o
// cfg     | in        | cfg_we_i                | cfg_idx_i, cfg_wdata_i
//
// First block of a message: key expansion (one schedule step per cycle into the round
// key RAM), then encryption of the zero block to derive the subkeys, then the block.
// Each block: a load step, add-key and ten rounds through the one shared round unit
// (the next round key is addressed a round ahead, as the RAM read is registered), and an
// output step; ready is low from the accept until the block is done.
// A final block then holds the MAC in the output register until the transaction completes.
// Reset clears control and the chaining value; the round key RAM is always refilled
// before it is read.
module aes128_cmac_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        blk_valid_i,
  output logic        blk_ready_o,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  input  logic [4:0]  valid_bytes_i,
  input  logic        final_block_i,
  output logic        mac_valid_o,
  input  logic        mac_ready_i,
  output logic [63:0] mac_high_o,
  output logic [63:0] mac_low_o
);
  acmac_pkg::state_e st_q, st_d;
  logic [63:0]  key_hi_q, key_lo_q;
  logic [127:0] cv_q, cv_d;         // chaining value / AES state
  logic [127:0] k1_q, k1_d, k2_q, k2_d;
  logic [127:0] rk_q, rk_d;         // key schedule register
  logic [127:0] blk_q, blk_d;
  logic [4:0]   vb_q, vb_d;
  logic         fin_q, fin_d;
  logic         mid_q, mid_d;
  logic         sub_q, sub_d;       // current encryption derives subkeys
  logic [3:0]   rnd_q, rnd_d;
  logic         out_v_q, out_v_d;
  logic [127:0] mac_q, mac_d;

  logic         ram_we;
  logic [3:0]   ram_waddr, ram_raddr;
  logic [127:0] ram_rdata, rk_next, rnd_out;
  logic [127:0] padded, mask;
  logic         blk_acc;
  acmac_pkg::core_ctl_t ctl;

  acmac_ram #(.Width(128), .Depth(16)) u_rk_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(rk_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // round key rnd_q+1 from round key rnd_q
  acmac_keyexp u_kexp (.key_i(rk_q), .rnd_i(rnd_q + 4'd1), .key_o(rk_next));

  acmac_round u_round (
    .state_i(cv_q),
    .rkey_i (ram_rdata),
    .last_i (rnd_q == 4'(acmac_pkg::NumRounds)),
    .state_o(rnd_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_hi_q <= '0;
      key_lo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (acmac_pkg::cfg_idx_e'(cfg_idx_i))
        acmac_pkg::CfgKeyHigh: key_hi_q <= cfg_wdata_i;
        acmac_pkg::CfgKeyLow:  key_lo_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign blk_ready_o = (st_q == acmac_pkg::StIdle) && !out_v_q;
  assign blk_acc = blk_valid_i && blk_ready_o;
  assign ctl.start = blk_acc;
  assign ctl.first = !mid_q;

  // pad: keep valid leading bytes, 0x80 at the first invalid byte, zeros after
  always_comb begin
    mask = '0;
    padded = blk_q;
    for (int i = 0; i < 16; i++) begin
      if (5'(i) >= vb_q) begin
        padded[127-8*i -: 8] = (5'(i) == vb_q) ? acmac_pkg::PadByte : 8'h00;
      end
    end
    mask = (vb_q >= acmac_pkg::FullBytes) ? (blk_q ^ k1_q) : (padded ^ k2_q);
  end

  always_comb begin
    st_d = st_q; cv_d = cv_q; k1_d = k1_q; k2_d = k2_q; rk_d = rk_q;
    blk_d = blk_q; vb_d = vb_q; fin_d = fin_q; mid_d = mid_q; sub_d = sub_q;
    rnd_d = rnd_q; out_v_d = out_v_q; mac_d = mac_q;
    ram_we = 1'b0; ram_waddr = rnd_q; ram_raddr = rnd_q;
    if (out_v_q && mac_ready_i) out_v_d = 1'b0;
    unique case (st_q)
      acmac_pkg::StIdle: begin
        if (ctl.start) begin
          blk_d = {block_high_i, block_low_i};
          vb_d = valid_bytes_i;
          fin_d = final_block_i;
          if (ctl.first) begin
            rk_d = {key_hi_q, key_lo_q};
            rnd_d = '0;
            st_d = acmac_pkg::StKeyExp;
          end else begin
            st_d = acmac_pkg::StLoad;
          end
        end
      end
      acmac_pkg::StKeyExp: begin
        // write key rnd, derive key rnd+1
        ram_we = 1'b1;
        rnd_d = rnd_q + 4'd1;
        rk_d = rk_next;
        if (rnd_q == 4'(acmac_pkg::NumRounds)) begin
          st_d = acmac_pkg::StSubkey;
        end
      end
      acmac_pkg::StSubkey: begin
        cv_d = '0;
        sub_d = 1'b1;
        mid_d = 1'b1;
        rnd_d = '0;
        ram_raddr = '0;
        st_d = acmac_pkg::StEnc;
      end
      acmac_pkg::StLoad: begin
        cv_d = cv_q ^ (fin_q ? mask : blk_q);
        sub_d = 1'b0;
        rnd_d = '0;
        ram_raddr = '0;
        st_d = acmac_pkg::StEnc;
      end
      acmac_pkg::StEnc: begin
        // ram_rdata holds round key rnd_q
        ram_raddr = rnd_q + 4'd1;
        rnd_d = rnd_q + 4'd1;
        if (rnd_q == '0) begin
          cv_d = cv_q ^ ram_rdata;
        end else begin
          cv_d = rnd_out;
        end
        if (rnd_q == 4'(acmac_pkg::NumRounds)) begin
          st_d = acmac_pkg::StOut;
        end
      end
      acmac_pkg::StOut: begin
        if (sub_q) begin
          k1_d = acmac_pkg::dbl(cv_q);
          k2_d = acmac_pkg::dbl(acmac_pkg::dbl(cv_q));
          cv_d = '0;
          st_d = acmac_pkg::StLoad;
        end else if (fin_q) begin
          mac_d = cv_q;
          out_v_d = 1'b1;
          cv_d = '0;
          mid_d = 1'b0;
          st_d = acmac_pkg::StIdle;
        end else begin
          st_d = acmac_pkg::StIdle;
        end
      end
      default: st_d = acmac_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= acmac_pkg::StIdle;
      cv_q <= '0;
      mid_q <= 1'b0;
      sub_q <= 1'b0;
      rnd_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cv_q <= cv_d;
      mid_q <= mid_d;
      sub_q <= sub_d;
      rnd_q <= rnd_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k1_q <= k1_d;
    k2_q <= k2_d;
    rk_q <= rk_d;
    blk_q <= blk_d;
    vb_q <= vb_d;
    fin_q <= fin_d;
    mac_q <= mac_d;
  end

  assign mac_valid_o = out_v_q;
  assign mac_high_o = mac_q[127:64];
  assign mac_low_o = mac_q[63:0];
endmodule

// File: hdl/acmac_checker.sv
`timescale 1ns / 1ps
module acmac_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        blk_valid_i,
  input logic        blk_ready_o,
  input logic        final_block_i,
  input logic        mac_valid_o,
  input logic        mac_ready_i,
  input logic [63:0] mac_high_o,
  input logic [63:0] mac_low_o
);
  a_mac_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_valid_o && !mac_ready_i |=> mac_valid_o && $stable(mac_high_o) && $stable(mac_low_o))
    else $error("mac dropped or changed while stalled");

  a_busy_after_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid_i && blk_ready_o |=> !blk_ready_o)
    else $error("block accepted without busy period");

  a_no_ready_with_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_valid_o |-> !blk_ready_o)
    else $error("ready while mac pending");

  a_nonfinal_no_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_valid_i && blk_ready_o && !final_block_i |=> !mac_valid_o)
    else $error("mac from non-final block");
endmodule

bind aes128_cmac_engine acmac_checker u_acmac_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .blk_valid_i  (blk_valid_i),
  .blk_ready_o  (blk_ready_o),
  .final_block_i(final_block_i),
  .mac_valid_o  (mac_valid_o),
  .mac_ready_i  (mac_ready_i),
  .mac_high_o   (mac_high_o),
  .mac_low_o    (mac_low_o)
);
